// ===== rtl/core/fmbpd_pkg.sv =====
package fmbpd_pkg;

	localparam int FRAME_BITS  = 40;
	localparam int QUEUE_DEPTH = 4;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_HIGH = 3'd1;
	localparam logic [2:0] ST_SHORT   = 3'd2;
	localparam logic [2:0] ST_SYNC    = 3'd3;
	localparam logic [2:0] ST_PARITY  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_SLICE = 2'd0;
	localparam logic [1:0] CFG_START = 2'd1;
	localparam logic [1:0] CFG_CELL  = 2'd2;

	localparam logic [15:0] SLICE_RST = 16'd32500;
	localparam logic [11:0] START_RST = 12'd0;
	localparam logic [7:0]  CELL_RST  = 8'd30;

	// frame sync patterns
	localparam logic [3:0] SYNC_CLOCK = 4'd3;
	localparam logic [6:0] SYNC_LEAD  = 7'd114;
	localparam logic [6:0] SYNC_TRAIL = 7'd13;

	// classified sample, front to back
	typedef struct packed {
		logic level;   // sliced level
		logic decode;  // index still inside the decodable window
		logic armed;   // index at or past search_start
		logic last;    // line ends here
	} item_ctl_t;

	// line summary handed to the frame check
	typedef struct packed {
		logic                  seek;
		logic                  full;
		logic [FRAME_BITS-1:0] frame;
	} frame_snap_t;

endpackage

// ===== rtl/core/fmbpd_front.sv =====
module fmbpd_front #(
	parameter int MAX_LINE_SAMPLES = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic [15:0]                           sample,
	input  logic                                  last_sample,
	input  logic [15:0]                           slice_level,
	input  logic [11:0]                           search_start,
	output fmbpd_pkg::item_ctl_t                  item_ctl,
	output logic [$clog2(MAX_LINE_SAMPLES+1)-1:0] item_idx
);

	localparam int IW = $clog2(MAX_LINE_SAMPLES + 1);
	localparam int CW = (IW > 12) ? IW : 12;
	localparam logic [IW-1:0] IDX_END = IW'(MAX_LINE_SAMPLES);

	logic [IW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			if (last_sample) begin
				idx_q <= '0;
			end else if (idx_q < IDX_END) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	always_comb begin
		item_ctl.level  = sample > slice_level;
		item_ctl.decode = idx_q < IDX_END;
		item_ctl.armed  = CW'(idx_q) >= CW'(search_start);
		item_ctl.last   = last_sample;
	end

	assign item_idx = idx_q;

endmodule

// ===== rtl/core/fmbpd_queue.sv =====
module fmbpd_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int DEPTH = fmbpd_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    cnt_q;

	assign full     = cnt_q == NW'(DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/fmbpd_back.sv =====
module fmbpd_back #(
	parameter int MAX_LINE_SAMPLES = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	output logic                                  q_pop,
	input  fmbpd_pkg::item_ctl_t                  item_ctl,
	input  logic [$clog2(MAX_LINE_SAMPLES+1)-1:0] item_idx,
	input  logic [7:0]                            cell_limit,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [2:0]                            status,
	output logic [19:0]                           frame_data,
	output logic                                  field_bit
);

	localparam int IW = $clog2(MAX_LINE_SAMPLES + 1);
	localparam int FB = fmbpd_pkg::FRAME_BITS;

	localparam logic [1:0] PH_SEEK  = 2'd0;
	localparam logic [1:0] PH_BIT   = 2'd1;
	localparam logic [1:0] PH_CLOSE = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	logic [1:0]    phase_q, phase_n;
	logic          held_q, held_n;
	logic [IW-1:0] chg_q, chg_n;
	logic [5:0]    cnt_q, cnt_n;
	logic [FB-1:0] shift_q, shift_n;
	logic          one_bit;

	fmbpd_pkg::frame_snap_t snap_s1;
	logic                   snap_valid_s1;
	logic                   snap_adv;
	logic                   out_valid_q;
	logic [2:0]             status_q, status_n;
	logic [19:0]            data_q, data_n;
	logic                   field_q, field_n;

	assign snap_adv = snap_valid_s1 && (!out_valid_q || !out_stall);
	assign q_pop    = !q_empty && (!snap_valid_s1 || snap_adv);

	// one per-sample step of the biphase-mark decoder
	always_comb begin
		phase_n = phase_q;
		held_n  = held_q;
		chg_n   = chg_q;
		cnt_n   = cnt_q;
		shift_n = shift_q;
		one_bit = (item_idx - chg_q) < IW'(cell_limit);
		if (item_ctl.decode) begin
			case (phase_q)
				PH_SEEK: begin
					if (item_ctl.armed && item_ctl.level) begin
						phase_n = PH_BIT;
						held_n  = 1'b1;
						chg_n   = item_idx;
					end
				end
				PH_BIT: begin
					if (item_ctl.level != held_q) begin
						held_n  = item_ctl.level;
						chg_n   = item_idx;
						shift_n = {shift_q[FB-2:0], one_bit};
						cnt_n   = cnt_q + 6'd1;
						phase_n = one_bit ? PH_CLOSE : PH_BIT;
						if (cnt_n >= 6'(FB)) begin
							phase_n = PH_DONE;
						end
					end
				end
				PH_CLOSE: begin
					if (item_ctl.level != held_q) begin
						held_n  = item_ctl.level;
						chg_n   = item_idx;
						phase_n = PH_BIT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			held_q  <= 1'b0;
			chg_q   <= '0;
			cnt_q   <= '0;
			shift_q <= '0;
		end else if (q_pop) begin
			if (item_ctl.last) begin
				phase_q <= PH_SEEK;
				held_q  <= 1'b0;
				chg_q   <= '0;
				cnt_q   <= '0;
				shift_q <= '0;
			end else begin
				phase_q <= phase_n;
				held_q  <= held_n;
				chg_q   <= chg_n;
				cnt_q   <= cnt_n;
				shift_q <= shift_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (q_pop) begin
			snap_valid_s1 <= item_ctl.last;
		end else if (snap_adv) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && item_ctl.last) begin
			snap_s1.seek  <= phase_n == PH_SEEK;
			snap_s1.full  <= cnt_n >= 6'(FB);
			snap_s1.frame <= shift_n;
		end
	end

	// frame check
	always_comb begin
		data_n  = '0;
		field_n = 1'b0;
		if (snap_s1.seek) begin
			status_n = fmbpd_pkg::ST_NO_HIGH;
		end else if (!snap_s1.full) begin
			status_n = fmbpd_pkg::ST_SHORT;
		end else if (snap_s1.frame[39:36] != fmbpd_pkg::SYNC_CLOCK
				|| snap_s1.frame[34:28] != fmbpd_pkg::SYNC_LEAD
				|| snap_s1.frame[6:0] != fmbpd_pkg::SYNC_TRAIL) begin
			status_n = fmbpd_pkg::ST_SYNC;
		end else if (!(^snap_s1.frame[27:7])) begin
			status_n = fmbpd_pkg::ST_PARITY;
		end else begin
			status_n = fmbpd_pkg::ST_OK;
			data_n   = snap_s1.frame[27:8];
			field_n  = snap_s1.frame[35];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_adv) begin
			status_q <= status_n;
			data_q   <= data_n;
			field_q  <= field_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign frame_data = data_q;
	assign field_bit  = field_q;

endmodule

// ===== rtl/core/fm_biphase_line_code_decoder_core.sv =====
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_stall   | sample, last_sample
// out     | output    | out_valid / out_stall | status, frame_data, field_bit
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One sample per cycle sustained while in_stall is low. A result is registered once the line's last
// sample passes the queue, the decode step into the snapshot register and the frame check into the output register.
// With one result stalled at the output and the next one waiting, the decoder holds
// and the 4-entry queue absorbs up to four samples before in_stall rises.
// Reset clears the line state and loads the register defaults; no clearing pass.
module fm_biphase_line_code_decoder_core #(
	parameter int MAX_LINE_SAMPLES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] sample,
	input  logic        last_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [19:0] frame_data,
	output logic        field_bit,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IW = $clog2(MAX_LINE_SAMPLES + 1);
	localparam int QW = $bits(fmbpd_pkg::item_ctl_t) + IW;

	logic [15:0] slice_q;
	logic [11:0] start_q;
	logic [7:0]  cell_q;

	fmbpd_pkg::item_ctl_t front_ctl, back_ctl;
	logic [IW-1:0]        front_idx, back_idx;
	logic                 in_take;
	logic                 q_full, q_empty, q_pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign in_take   = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= fmbpd_pkg::SLICE_RST;
			start_q <= fmbpd_pkg::START_RST;
			cell_q  <= fmbpd_pkg::CELL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fmbpd_pkg::CFG_SLICE: slice_q <= cfg_data;
				fmbpd_pkg::CFG_START: start_q <= cfg_data[11:0];
				fmbpd_pkg::CFG_CELL:  cell_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	fmbpd_front #(
		.MAX_LINE_SAMPLES(MAX_LINE_SAMPLES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (in_take),
		.sample      (sample),
		.last_sample (last_sample),
		.slice_level (slice_q),
		.search_start(start_q),
		.item_ctl    (front_ctl),
		.item_idx    (front_idx)
	);

	fmbpd_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_take),
		.push_data({front_ctl, front_idx}),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data ({back_ctl, back_idx}),
		.empty    (q_empty)
	);

	fmbpd_back #(
		.MAX_LINE_SAMPLES(MAX_LINE_SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.item_ctl  (back_ctl),
		.item_idx  (back_idx),
		.cell_limit(cell_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.frame_data(frame_data),
		.field_bit (field_bit)
	);

endmodule

// ===== rtl/core/fmbpd_checker.sv =====
module fmbpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [19:0] frame_data,
	input logic        field_bit
);

	// a stalled result stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(frame_data)
			&& $stable(field_bit))
		else $error("result changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == fmbpd_pkg::ST_OK || status == fmbpd_pkg::ST_NO_HIGH
			|| status == fmbpd_pkg::ST_SHORT || status == fmbpd_pkg::ST_SYNC
			|| status == fmbpd_pkg::ST_PARITY)
		else $error("undefined status code");

	a_fail_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != fmbpd_pkg::ST_OK |-> frame_data == '0 && !field_bit)
		else $error("payload set on a failed frame");

endmodule

bind fm_biphase_line_code_decoder_core fmbpd_checker u_fmbpd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.frame_data(frame_data),
	.field_bit (field_bit)
);
